[rtl/set_assoc_cache_lookup_top_assert.svh]
// Assertion macros shared by the cache lookup modules.
`ifndef SET_ASSOC_CACHE_LOOKUP_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_LOOKUP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on clk, muted while arst_n is low.
`define SACL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check a property on clk, also across reset.
`define SACL_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SACL_ASSERT(lbl, prop, msg)
`define SACL_ASSERT_NR(lbl, prop, msg)
`endif
`endif

[rtl/sacl_pkg.sv]
package sacl_pkg;
	localparam int SETS      = 256;
	localparam int WAYS      = 4;
	localparam int ADDR_BITS = 32;
	localparam int SET_BITS  = $clog2(SETS);
	localparam int WAY_BITS  = $clog2(WAYS);
	localparam int AGE_BITS  = $clog2(WAYS);
	localparam int K_BITS    = 4;
	localparam int CFG_BITS  = 4;

	localparam logic [1:0] ST_HIT   = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_DIRTY = 2'd2;

	localparam logic REG_POLICY    = 1'b0;
	localparam logic REG_SETS_LOG2 = 1'b1;

	typedef enum logic {
		S_IDLE,
		S_LOOKUP
	} state_t;

	typedef struct packed {
		logic capture;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] tag;
		logic                 valid;
		logic                 dirty;
		logic [AGE_BITS-1:0]  age;
	} way_t;

	typedef struct packed {
		way_t [WAYS-1:0]     ways;
		logic [WAY_BITS-1:0] ptr;
	} row_t;

	// Clamp the requested log2 set count to what the store holds.
	function automatic logic [K_BITS-1:0] bits_in_use(input logic [K_BITS-1:0] req);
		logic [K_BITS-1:0] lim;
		lim = K_BITS'(SET_BITS);
		return (req > lim) ? lim : req;
	endfunction

	function automatic logic [SET_BITS-1:0] set_of(input logic [ADDR_BITS-1:0] a,
		input logic [K_BITS-1:0] k);
		logic [SET_BITS-1:0] s;
		for (int i = 0; i < SET_BITS; i++) begin
			s[i] = a[i] && (i < int'(k));
		end
		return s;
	endfunction
endpackage

[rtl/sacl_ctrl.sv]
`include "set_assoc_cache_lookup_top_assert.svh"
module sacl_ctrl import sacl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output cmd_t cmd
);
	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_nx = S_LOOKUP;
			end
			S_LOOKUP: state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b0;
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.capture = start;
			S_LOOKUP: begin
				busy = 1'b1;
				cmd.update = 1'b1;
			end
			default: busy = 1'b0;
		endcase
	end

	`SACL_ASSERT(a_accept_busy, start && !busy |=> busy, "accept did not enter lookup")
	`SACL_ASSERT_NR(a_busy_one, busy |=> !busy, "lookup held longer than one cycle")
	`SACL_ASSERT(a_upd_capt, cmd.update |-> $past(cmd.capture), "update without capture")
endmodule

[rtl/sacl_datapath.sv]
`include "set_assoc_cache_lookup_top_assert.svh"
module sacl_datapath import sacl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic [ADDR_BITS-1:0] block_address,
	input  logic                 is_write,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_BITS-1:0]  cfg_data,
	output logic                 done,
	output logic [1:0]           status,
	output logic [WAY_BITS-1:0]  way_used,
	output logic [ADDR_BITS-1:0] victim_address
);
	row_t                 mem [SETS];
	logic [SETS-1:0]      rowv_q;
	logic                 policy_q;
	logic [K_BITS-1:0]    slog2_q;
	logic [K_BITS-1:0]    k;
	logic [SET_BITS-1:0]  set_in;

	row_t                 rd_row_s1;
	logic                 rowv_s1;
	logic [SET_BITS-1:0]  set_s1;
	logic [ADDR_BITS-1:0] tag_s1;
	logic                 wr_s1;

	row_t                 cur, new_row;
	logic                 hit, has_inv, use_fifo;
	logic [WAY_BITS-1:0]  hit_way, inv_way, lru_way, way;
	logic [AGE_BITS:0]    old_age;
	logic [1:0]           st;
	logic [ADDR_BITS-1:0] victim;

	logic                 done_q;
	logic [1:0]           status_q;
	logic [WAY_BITS-1:0]  way_q;
	logic [ADDR_BITS-1:0] victim_q;

	assign k      = bits_in_use(slog2_q);
	assign set_in = set_of(block_address, k);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b0;
			slog2_q  <= K_BITS'(SET_BITS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLICY:    policy_q <= cfg_data[0];
				REG_SETS_LOG2: slog2_q  <= cfg_data;
				default:       policy_q <= policy_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_row_s1 <= mem[set_in];
		end
		if (cmd.update) begin
			mem[set_s1] <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rowv_q <= '0;
		end else if (cmd.update) begin
			rowv_q[set_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rowv_s1 <= rowv_q[set_in];
			set_s1  <= set_in;
			tag_s1  <= block_address >> k;
			wr_s1   <= is_write;
		end
	end

	assign cur = rowv_s1 ? rd_row_s1 : '0;

	always_comb begin
		hit = 1'b0;
		hit_way = '0;
		has_inv = 1'b0;
		inv_way = '0;
		lru_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (cur.ways[w].valid && cur.ways[w].tag == tag_s1) begin
				hit = 1'b1;
				hit_way = WAY_BITS'(w);
			end
			if (!cur.ways[w].valid) begin
				has_inv = 1'b1;
				inv_way = WAY_BITS'(w);
			end
		end
		for (int w = 1; w < WAYS; w++) begin
			if (cur.ways[w].age > cur.ways[lru_way].age) lru_way = WAY_BITS'(w);
		end
	end

	always_comb begin
		new_row  = cur;
		use_fifo = 1'b0;
		victim   = '0;
		st       = ST_MISS;
		priority if (hit) begin
			way = hit_way;
			st = ST_HIT;
		end else if (has_inv) begin
			way = inv_way;
		end else begin
			use_fifo = policy_q;
			way = policy_q ? cur.ptr : lru_way;
			if (cur.ways[way].dirty) begin
				st = ST_DIRTY;
				victim = (cur.ways[way].tag << k) | ADDR_BITS'(set_s1);
			end
		end
		old_age = hit ? {1'b0, cur.ways[way].age} : (AGE_BITS+1)'(WAYS);
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_BITS'(w) != way && cur.ways[w].valid &&
				{1'b0, cur.ways[w].age} < old_age &&
				cur.ways[w].age < AGE_BITS'(WAYS - 1)) begin
				new_row.ways[w].age = cur.ways[w].age + 1'b1;
			end
		end
		new_row.ways[way].age = '0;
		if (hit) begin
			new_row.ways[way].dirty = cur.ways[way].dirty | wr_s1;
		end else begin
			new_row.ways[way].tag   = tag_s1;
			new_row.ways[way].valid = 1'b1;
			new_row.ways[way].dirty = wr_s1;
		end
		if (use_fifo) new_row.ptr = way + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.update;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			status_q <= st;
			way_q    <= way;
			victim_q <= victim;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign way_used       = way_q;
	assign victim_address = victim_q;

	`SACL_ASSERT(a_strobe_src, done |-> $past(cmd.update), "strobe without lookup")
	`SACL_ASSERT(a_upd_strobe, cmd.update |=> done, "lookup lost its result")
	`SACL_ASSERT(a_victim_zero, done && status != ST_DIRTY |-> victim_address == '0, "stray victim")
endmodule

[rtl/set_assoc_cache_lookup_top.sv]
// Set-associative write-back cache tag lookup, 256 sets by 4 ways, LRU or FIFO
// replacement. Raise start with block_address and is_write; the access is taken
// at the edge where start is high and busy is low. The set row is read from the
// tag memory at the accept edge, then compared, updated and written back in the
// next cycle (busy high), so no new access is taken while busy is high. The
// result appears on status, way_used and victim_address for exactly one cycle,
// marked by done, in the cycle after busy; there is no way to stall it, so
// sample it when done is high. Configuration (cfg_we, cfg_index, cfg_data)
// must be written only while idle; the block itself does not enforce this. The
// tag memory is cleared at reset by one valid flop per set row, so there is no
// clearing pass and the block is ready right after reset.
module set_assoc_cache_lookup_top import sacl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [ADDR_BITS-1:0] block_address,
	input  logic                 is_write,
	output logic                 done,
	output logic [1:0]           status,
	output logic [WAY_BITS-1:0]  way_used,
	output logic [ADDR_BITS-1:0] victim_address,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_BITS-1:0]  cfg_data
);
	// Commands from the sequencer: capture the beat, then update the set.
	cmd_t cmd;

	sacl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Tag memory, lookup, replacement choice and result register.
	sacl_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.block_address  (block_address),
		.is_write       (is_write),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.done           (done),
		.status         (status),
		.way_used       (way_used),
		.victim_address (victim_address)
	);
endmodule

[dv/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sacl_pkg::*;

	// Pending access: block address plus write flag.
	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		logic                 wr;
	} access_t;

	// Expected lookup outcome, one per accepted access.
	typedef struct packed {
		logic [1:0]           status;
		logic [WAY_BITS-1:0]  way;
		logic [ADDR_BITS-1:0] victim;
	} lookup_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [ADDR_BITS-1:0] block_address;
	logic                 is_write;
	logic                 done;
	logic [1:0]           status;
	logic [WAY_BITS-1:0]  way_used;
	logic [ADDR_BITS-1:0] victim_address;
	logic                 cfg_we;
	logic                 cfg_index;
	logic [CFG_BITS-1:0]  cfg_data;

	set_assoc_cache_lookup_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.block_address(block_address), .is_write(is_write), .done(done),
		.status(status), .way_used(way_used), .victim_address(victim_address),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the tag store, kept in step with every accepted beat.
	logic [ADDR_BITS-1:0] shadow_tag [SETS][WAYS];
	logic                 shadow_valid [SETS][WAYS];
	logic                 shadow_dirty [SETS][WAYS];
	int unsigned          shadow_age [SETS][WAYS];
	int unsigned          shadow_ptr [SETS];
	logic                 cur_policy;
	logic [3:0]           cur_sets_log2;

	access_t pending_q[$];
	lookup_t lookup_q[$];

	int     errors = 0;
	int     idle_cycles = 0;
	int     burst_left = 0;
	int     gap_left = 0;
	bit     stim_done = 0;
	int     accepted = 0;

	localparam int WATCHDOG = 2000;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Promote touched way to most recent; younger valid ways age by one.
	function automatic void age_set(int unsigned s, int unsigned w, int unsigned old_age);
		for (int i = 0; i < WAYS; i++) begin
			if (i != w && shadow_valid[s][i] && shadow_age[s][i] < old_age &&
				shadow_age[s][i] < WAYS - 1)
				shadow_age[s][i]++;
		end
		shadow_age[s][w] = 0;
	endfunction

	// Compute the lookup outcome for one access and update the shadow state.
	function automatic lookup_t lookup_access(access_t a);
		lookup_t      r;
		int unsigned  k;
		int unsigned  s;
		logic [ADDR_BITS-1:0] tg;
		bit           found;
		int unsigned  best;
		k = (cur_sets_log2 > SET_BITS) ? SET_BITS : cur_sets_log2;
		s = a.addr & ((32'd1 << k) - 1);
		tg = a.addr >> k;
		found = 0;
		r = '0;
		r.status = ST_MISS;
		for (int w = 0; w < WAYS; w++) begin
			if (!found && shadow_valid[s][w] && shadow_tag[s][w] == tg) begin
				found = 1;
				r.status = ST_HIT;
				r.way = WAY_BITS'(w);
				if (a.wr) shadow_dirty[s][w] = 1;
				age_set(s, w, shadow_age[s][w]);
			end
		end
		if (!found) begin
			for (int w = 0; w < WAYS; w++) begin
				if (!found && !shadow_valid[s][w]) begin
					found = 1;
					r.way = WAY_BITS'(w);
				end
			end
			if (!found) begin
				if (cur_policy) begin
					r.way = WAY_BITS'(shadow_ptr[s] % WAYS);
					shadow_ptr[s] = (r.way + 1) % WAYS;
				end else begin
					best = 0;
					for (int w = 1; w < WAYS; w++)
						if (shadow_age[s][w] > shadow_age[s][best]) best = w;
					r.way = WAY_BITS'(best);
				end
				if (shadow_dirty[s][r.way]) begin
					r.status = ST_DIRTY;
					r.victim = (shadow_tag[s][r.way] << k) | s;
				end
			end
			shadow_tag[s][r.way] = tg;
			shadow_valid[s][r.way] = 1;
			shadow_dirty[s][r.way] = a.wr;
			age_set(s, r.way, WAYS);
		end
		return r;
	endfunction

	// Driver: bursts of back-to-back beats with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			block_address <= '0;
			is_write <= 0;
		end else begin
			if (start && !busy) begin
				lookup_q.push_back(lookup_access('{addr: block_address, wr: is_write}));
				accepted++;
			end
			if (start && busy) begin
				// hold the current beat until it is taken
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 0;
			end else if (pending_q.size() > 0) begin
				access_t a;
				a = pending_q.pop_front();
				start <= 1;
				block_address <= a.addr;
				is_write <= a.wr;
				if (burst_left > 0) burst_left--;
				else begin
					burst_left = $urandom_range(0, 20);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				start <= 0;
			end
		end
	end

	// Monitor: results cannot be stalled, so check every done cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (done) begin
				if (lookup_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result status=%0d", status);
				end else begin
					lookup_t e;
					e = lookup_q.pop_front();
					if (status !== e.status || way_used !== e.way ||
						victim_address !== e.victim) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp st=%0d way=%0d vic=%h got st=%0d way=%0d vic=%h",
								e.status, e.way, e.victim, status, way_used, victim_address);
					end
				end
			end
			if (idle_cycles >= WATCHDOG) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic write_reg(logic idx, logic [CFG_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_POLICY) cur_policy = val[0];
		else cur_sets_log2 = val;
	endtask

	// Let the queued beats drain and every result arrive.
	task automatic drain();
		while (pending_q.size() > 0 || start || lookup_q.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly addresses from a small working set so that sets fill and evict.
	function automatic access_t rand_access(int unsigned span);
		access_t a;
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) a.addr = $urandom();
		else a.addr = ($urandom_range(0, span) << 4) | $urandom_range(0, 3);
		if ($urandom_range(0, 7) == 0) a.addr = a.addr ^ (32'h1 << $urandom_range(0, 31));
		a.wr = 1'($urandom_range(0, 1));
		return a;
	endfunction

	initial begin
		logic [3:0] log2_set [6];
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_POLICY;
		cfg_data = '0;
		cur_policy = 0;
		cur_sets_log2 = 8;
		for (int s = 0; s < SETS; s++) begin
			shadow_ptr[s] = 0;
			for (int w = 0; w < WAYS; w++) begin
				shadow_tag[s][w] = '0;
				shadow_valid[s][w] = 0;
				shadow_dirty[s][w] = 0;
				shadow_age[s][w] = 0;
			end
		end
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, fill, hit, dirty eviction under LRU, zero-set split.
		write_reg(REG_SETS_LOG2, 4'd0);
		pending_q.push_back('{addr: 32'h0, wr: 1'b0});
		pending_q.push_back('{addr: 32'hFFFF_FFFF, wr: 1'b1});
		pending_q.push_back('{addr: 32'h0, wr: 1'b1});
		pending_q.push_back('{addr: 32'h5555_5555, wr: 1'b1});
		pending_q.push_back('{addr: 32'hAAAA_AAAA, wr: 1'b0});
		pending_q.push_back('{addr: 32'h1234_5678, wr: 1'b1});
		pending_q.push_back('{addr: 32'h0, wr: 1'b0});
		pending_q.push_back('{addr: 32'h8000_0000, wr: 1'b1});
		drain();
		// Too many sets requested: clamps to the store size.
		write_reg(REG_SETS_LOG2, 4'd15);
		pending_q.push_back('{addr: 32'hFFFF_FFFF, wr: 1'b0});
		pending_q.push_back('{addr: 32'h0000_01FF, wr: 1'b1});
		pending_q.push_back('{addr: 32'h8000_00FF, wr: 1'b1});
		drain();
		// FIFO on a single set, with dirty victims; then split changes mid-run.
		write_reg(REG_POLICY, 4'd1);
		write_reg(REG_SETS_LOG2, 4'd1);
		for (int i = 0; i < 7; i++) pending_q.push_back('{addr: i * 2, wr: i[0]});
		drain();
		write_reg(REG_SETS_LOG2, 4'd2);
		for (int i = 0; i < 6; i++) pending_q.push_back('{addr: i * 2, wr: 1'b1});
		drain();

		// Random phases over a spread of settings.
		log2_set = '{4'd8, 4'd0, 4'd3, 4'd15, 4'd1, 4'd6};
		for (int p = 0; p < 12; p++) begin
			int unsigned span;
			write_reg(REG_POLICY, CFG_BITS'(p[0]));
			write_reg(REG_SETS_LOG2, log2_set[p % 6]);
			span = (p % 3 == 0) ? 255 : 31;
			for (int i = 0; i < 150; i++) pending_q.push_back(rand_access(span));
			drain();
		end
		stim_done = 1;
		repeat (10) @(posedge clk);
		if (errors == 0 && lookup_q.size() == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
